### sv/gaba_pkg.sv
package gaba_pkg;

  localparam int SIZE_BITS       = 32;
  localparam int CAP_BITS        = 40;
  localparam int ID_BITS         = 8;
  localparam int NID_BITS        = 9;
  localparam int MAX_BLOCKS      = 256;
  localparam int MIN_BLOCK_BYTES = 4096;
  localparam int FIRST_RESET     = 4096;

  localparam logic [SIZE_BITS-1:0] SIZE_TOP = {SIZE_BITS{1'b1}};
  localparam logic [CAP_BITS-1:0]  CAP_TOP  = {CAP_BITS{1'b1}};

  // Operation codes of the request word.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FIRST_BLOCK = 1'b0;
  localparam logic CFG_BYTE_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_REQ = 2'd1,
    ST_NO_ROOM = 2'd2,
    ST_BAD_CFG = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [3:0]  align_log2;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  block_number;
    logic [31:0] offset;
    logic [39:0] capacity;
    logic [39:0] used_total;
  } rsp_t;

  // Arena state that every request reads and may update.
  typedef struct packed {
    logic [SIZE_BITS-1:0] cur_bytes;
    logic [SIZE_BITS-1:0] fill;
    logic [CAP_BITS-1:0]  cap;
    logic [CAP_BITS-1:0]  granted;
    logic [ID_BITS-1:0]   cur_id;
    logic [NID_BITS-1:0]  next_id;
  } state_t;

  // Settings derived from the configuration registers.
  typedef struct packed {
    logic [SIZE_BITS-1:0] limit;
    logic [SIZE_BITS-1:0] first_kept;
    logic                 bad;
  } cfg_t;

endpackage

### sv/gaba_step.sv
module gaba_step
  import gaba_pkg::*;
(
  input  req_t   req,
  input  state_t st,
  input  cfg_t   cfg,
  output state_t st_next,
  output rsp_t   rsp
);

  logic [15:0]          amask;
  logic [16:0]          align;
  logic [32:0]          aligned;
  logic [33:0]          need;
  logic [31:0]          need32;
  logic                 bad_req;
  logic                 fits;
  logic [32:0]          dbl;
  logic [31:0]          base;
  logic [31:0]          sz1;
  logic [CAP_BITS-1:0]  lim40;
  logic [CAP_BITS-1:0]  rem;
  logic                 lim_refuse;
  logic [31:0]          sz;
  logic                 open_ok;
  logic [CAP_BITS:0]    cap_sum;
  logic [CAP_BITS:0]    grant_sum;

  function automatic logic [CAP_BITS-1:0] cap_sat(input logic [CAP_BITS:0] v);
    cap_sat = v[CAP_BITS] ? CAP_TOP : v[CAP_BITS-1:0];
  endfunction

  always_comb begin
    align   = 17'd1 << req.align_log2;
    amask   = 16'(align - 17'd1);
    aligned = ({1'b0, st.fill} + {17'd0, amask}) & ~{17'd0, amask};
    need    = {1'b0, aligned} + {2'b00, req.request_bytes};
    need32  = need[31:0];
    bad_req = (req.request_bytes == 32'd0) ||
              ({1'b0, req.request_bytes} > ({1'b0, SIZE_TOP} - {16'd0, align}));
    fits    = need <= {2'b00, st.cur_bytes};

    // Size of the next block before the limit is applied.
    dbl = {st.cur_bytes, 1'b0};
    if (st.cur_bytes < 32'(MIN_BLOCK_BYTES)) begin
      base = 32'(MIN_BLOCK_BYTES);
    end else if (dbl[32]) begin
      base = SIZE_TOP;
    end else begin
      base = dbl[31:0];
    end
    sz1 = (base < need32) ? need32 : base;

    // With capacity below the limit, cap + sz1 > limit is sz1 > limit - cap.
    lim40      = {8'd0, cfg.limit};
    rem        = lim40 - st.cap;
    lim_refuse = 1'b0;
    sz         = sz1;
    if (cfg.limit != 32'd0) begin
      if (st.cap >= lim40) begin
        lim_refuse = 1'b1;
      end else if ({8'd0, sz1} > rem) begin
        sz         = rem[31:0];
        lim_refuse = rem[31:0] < need32;
      end
    end

    open_ok = (need[33:32] == 2'b00) && (st.next_id < NID_BITS'(MAX_BLOCKS)) &&
              !lim_refuse && (sz != 32'd0);

    cap_sum   = {1'b0, st.cap} + {9'd0, sz};
    grant_sum = {1'b0, st.granted} + {9'd0, req.request_bytes};

    st_next = st;
    rsp.status       = ST_OK;
    rsp.offset       = '0;
    rsp.block_number = st.cur_id;
    rsp.capacity     = st.cap;
    rsp.used_total   = st.granted;

    if (cfg.bad) begin
      rsp.status       = ST_BAD_CFG;
      rsp.block_number = '0;
      rsp.capacity     = '0;
      rsp.used_total   = '0;
    end else if (req.opcode == OP_RESET) begin
      st_next.fill      = '0;
      st_next.cur_id    = '0;
      st_next.cur_bytes = cfg.first_kept;
      st_next.granted   = '0;
      rsp.block_number  = '0;
      rsp.used_total    = '0;
    end else if (bad_req) begin
      rsp.status = ST_BAD_REQ;
    end else if (fits) begin
      st_next.fill    = need32;
      st_next.granted = cap_sat(grant_sum);
      rsp.offset      = aligned[31:0];
      rsp.used_total  = cap_sat(grant_sum);
    end else if (open_ok) begin
      // The region starts at the head of the new block.
      st_next.cur_id    = st.next_id[ID_BITS-1:0];
      st_next.next_id   = st.next_id + NID_BITS'(1);
      st_next.cur_bytes = sz;
      st_next.cap       = cap_sat(cap_sum);
      st_next.fill      = req.request_bytes;
      st_next.granted   = cap_sat(grant_sum);
      rsp.block_number  = st.next_id[ID_BITS-1:0];
      rsp.capacity      = cap_sat(cap_sum);
      rsp.used_total    = cap_sat(grant_sum);
    end else begin
      rsp.status = ST_NO_ROOM;
    end
  end

endmodule

### sv/growing_arena_bump_allocator_unit.sv
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_t: opcode, request_bytes, align_log2
// rsp      out        rsp_valid/rsp_stall  rsp_t: status, block_number, offset,
//                                          capacity, used_total
// cfg      in         cfg_we               cfg_index, cfg_data
//
// A request word is captured in an input register and its result is formed
// combinationally into the output register, so one word is taken every cycle
// while the output is not stalled. The arena state is updated in the same
// cycle as the output register is loaded, which sets the rate. Reset restores
// the default configuration and an empty arena. A stalled output holds its
// word while the input register can still take one more word.
module growing_arena_bump_allocator_unit
  import gaba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] first_block_bytes;
  logic [31:0] byte_limit;
  logic [31:0] first_kept;
  logic        cfg_bad;
  state_t      st;
  req_t        in_q;
  logic        in_v;
  logic        advance;
  logic [31:0] first_next;
  logic [31:0] limit_next;
  logic [31:0] eff_next;
  cfg_t        cfg;
  state_t      st_step;
  rsp_t        rsp_step;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = in_v && !advance;

  assign cfg.limit      = byte_limit;
  assign cfg.first_kept = first_kept;
  assign cfg.bad        = cfg_bad;

  always_comb begin
    first_next = (cfg_index == CFG_FIRST_BLOCK) ? cfg_data : first_block_bytes;
    limit_next = (cfg_index == CFG_BYTE_LIMIT) ? cfg_data : byte_limit;
    eff_next   = (first_next < 32'(MIN_BLOCK_BYTES)) ? 32'(MIN_BLOCK_BYTES) : first_next;
  end

  gaba_step u_step (
    .req     (in_q),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_step),
    .rsp     (rsp_step)
  );

  function automatic state_t arena_start(input logic [31:0] e);
    state_t s;
    s.cur_bytes = e;
    s.fill      = '0;
    s.cap       = {8'd0, e};
    s.granted   = '0;
    s.cur_id    = '0;
    s.next_id   = NID_BITS'(1);
    arena_start = s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      first_block_bytes <= 32'(FIRST_RESET);
      byte_limit        <= '0;
      first_kept        <= 32'(FIRST_RESET);
      cfg_bad           <= 1'b0;
      st                <= arena_start(32'(FIRST_RESET));
      in_v              <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_block_bytes <= first_next;
        byte_limit        <= limit_next;
        first_kept        <= eff_next;
        cfg_bad           <= (limit_next != 32'd0) && (limit_next < eff_next);
        st                <= arena_start(eff_next);
      end else if (advance && in_v) begin
        st <= st_step;
      end
      if (advance) begin
        rsp_valid <= in_v;
      end
      if (req_valid && !req_stall) begin
        in_v <= 1'b1;
      end else if (advance) begin
        in_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_q <= req;
    end
    if (advance && in_v) begin
      rsp <= rsp_step;
    end
  end

endmodule

### tb/growing_arena_bump_allocator_unit_test.sv
`timescale 1ns / 1ps

module growing_arena_bump_allocator_unit_test;
  import gaba_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 6;
  localparam int MAX_WAIT     = 17;
  localparam logic [63:0] SIZE_MAX64 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] CAP_MAX64  = 64'h0000_00FF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_word = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_FIRST_BLOCK;
  logic [31:0] cfg_data = '0;

  growing_arena_bump_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the arena: configuration and allocation state.
  logic [63:0] cfg_first;
  logic [63:0] cfg_limit;
  logic        cfg_bad;
  logic [63:0] blk_bytes;
  logic [63:0] blk_fill;
  logic [63:0] cap_total;
  logic [63:0] granted_total;
  logic [63:0] blk_id;
  logic [63:0] next_id;
  logic [63:0] first_kept;

  req_t pending_words[$];
  rsp_t answers_due[$];
  rsp_t due_word;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   take_wait = 0;
  int   hold_left = 0;
  logic hold_arm = 1'b0;
  bit   steady_send = 1'b0;
  bit   steady_take = 1'b0;

  function automatic logic [63:0] cap_clip(input logic [63:0] v);
    return (v > CAP_MAX64) ? CAP_MAX64 : v;
  endfunction

  function automatic void arena_restart();
    logic [63:0] e;
    e = cfg_first;
    if (e < 64'(MIN_BLOCK_BYTES)) e = 64'(MIN_BLOCK_BYTES);
    if (e > SIZE_MAX64) e = SIZE_MAX64;
    first_kept    = e;
    blk_bytes     = e;
    blk_fill      = 0;
    cap_total     = cap_clip(e);
    granted_total = 0;
    blk_id        = 0;
    next_id       = 1;
    cfg_bad       = (cfg_limit != 0) && (cfg_limit < e);
  endfunction

  // Opens a new block of at least need bytes; zero means the block was refused.
  function automatic logic [63:0] open_block(input logic [63:0] need);
    logic [63:0] sz;
    if (need > SIZE_MAX64 || next_id >= 64'(MAX_BLOCKS)) return 0;
    sz = (blk_bytes < 64'(MIN_BLOCK_BYTES)) ? 64'(MIN_BLOCK_BYTES) : blk_bytes * 2;
    if (sz > SIZE_MAX64) sz = SIZE_MAX64;
    if (sz < need) sz = need;
    if (cfg_limit != 0 && cap_total + sz > cfg_limit) begin
      if (cap_total >= cfg_limit) return 0;
      sz = cfg_limit - cap_total;
      if (sz < need) return 0;
    end
    if (sz == 0) return 0;
    blk_id    = next_id;
    next_id   = next_id + 1;
    blk_bytes = sz;
    blk_fill  = 0;
    cap_total = cap_clip(cap_total + sz);
    return sz;
  endfunction

  function automatic rsp_t arena_answer(input req_t r);
    rsp_t        o;
    logic [63:0] align;
    logic [63:0] bytes;
    logic [63:0] spot;
    logic [63:0] opened;
    o = '0;
    if (cfg_bad) begin
      o.status = ST_BAD_CFG;
      return o;
    end
    o.status = ST_OK;
    align = 64'd1 << r.align_log2;
    bytes = {32'd0, r.request_bytes};
    spot  = 0;
    if (r.opcode == OP_RESET) begin
      blk_fill      = 0;
      blk_id        = 0;
      blk_bytes     = first_kept;
      granted_total = 0;
    end else if (bytes == 0 || bytes > SIZE_MAX64 - align) begin
      o.status = ST_BAD_REQ;
    end else begin
      spot = (blk_fill + align - 1) & ~(align - 1);
      if (spot + bytes > blk_bytes) begin
        opened = open_block(spot + bytes);
        if (opened == 0 || bytes > blk_bytes) o.status = ST_NO_ROOM;
        else spot = 0;
      end
      if (o.status == ST_OK) begin
        blk_fill      = spot + bytes;
        granted_total = cap_clip(granted_total + bytes);
      end else begin
        spot = 0;
      end
    end
    o.block_number = blk_id[7:0];
    o.offset       = spot[31:0];
    o.capacity     = cap_total[39:0];
    o.used_total   = granted_total[39:0];
    return o;
  endfunction

  function automatic req_t make_word(input logic op, input logic [31:0] bytes,
                                     input logic [3:0] align);
    req_t w;
    w.opcode        = op;
    w.request_bytes = bytes;
    w.align_log2    = align;
    return w;
  endfunction

  // Mostly small allocations, with resets, zero sizes and full-range sizes mixed in.
  function automatic req_t random_word();
    int          pick;
    logic [3:0]  align;
    logic [31:0] bytes;
    pick  = $urandom_range(0, 99);
    align = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                          4'($urandom_range(0, 6));
    if (pick < 6) return make_word(OP_RESET, $urandom, 4'($urandom_range(0, 15)));
    if (pick < 9) bytes = 0;
    else if (pick < 14) bytes = $urandom;
    else if (pick < 28) bytes = $urandom_range(4097, 1 << 20);
    else bytes = $urandom_range(1, 3000);
    return make_word(OP_ALLOC, bytes, align);
  endfunction

  task automatic compare_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Sender: one word per handshake, random gap after each word unless steady_send is set.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        answers_due.push_back(arena_answer(req_word));
        send_gap = steady_send ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          req_valid <= 1'b1;
          req_word  <= pending_words.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed from the stimulus process.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      take_wait = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: expected none, actual %0h", $time, rsp);
        end else begin
          due_word = answers_due.pop_front();
          compare_field("status", 40'(due_word.status), 40'(rsp.status));
          compare_field("block_number", 40'(due_word.block_number), 40'(rsp.block_number));
          compare_field("offset", 40'(due_word.offset), 40'(rsp.offset));
          compare_field("capacity", due_word.capacity, rsp.capacity);
          compare_field("used_total", due_word.used_total, rsp.used_total);
        end
        take_wait = steady_take ? 0 : $urandom_range(0, MAX_WAIT);
      end
      rsp_stall <= (take_wait != 0) || (hold_left != 0);
      if (take_wait != 0) take_wait--;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || req_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes happen only with the arena idle, so the shadow restarts at once.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_FIRST_BLOCK) cfg_first = {32'd0, value};
    else cfg_limit = {32'd0, value};
    arena_restart();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) pending_words.push_back(random_word());
    drain();
  endtask

  initial begin
    cfg_first = 64'(FIRST_RESET);
    cfg_limit = 0;
    arena_restart();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the default setting.
    pending_words.push_back(make_word(OP_ALLOC, 32'd1, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'd0, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'hFFFF_FFFF, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'hFFFF_8000, 4'd15));
    pending_words.push_back(make_word(OP_ALLOC, 32'hFFFF_7FFF, 4'd15));
    pending_words.push_back(make_word(OP_ALLOC, 32'd100, 4'd3));
    pending_words.push_back(make_word(OP_ALLOC, 32'hFFFF_0000, 4'd0));
    pending_words.push_back(make_word(OP_RESET, 32'hFFFF_FFFF, 4'd15));
    pending_words.push_back(make_word(OP_ALLOC, 32'd4096, 4'd12));
    pending_words.push_back(make_word(OP_ALLOC, 32'd1, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'd5, 4'd15));
    pending_words.push_back(make_word(OP_RESET, 32'd0, 4'd0));
    pending_words.push_back(make_word(OP_RESET, 32'd0, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'd4095, 4'd1));
    pending_words.push_back(make_word(OP_ALLOC, 32'd1, 4'd0));
    pending_words.push_back(make_word(OP_ALLOC, 32'h8000_0000, 4'd15));
    pending_words.push_back(make_word(OP_ALLOC, 32'h7FFF_FFFF, 4'd7));
    drain();
    run_random(30);

    // Reset-then-grow pairs open one block each until the block count runs out.
    write_reg(CFG_FIRST_BLOCK, 32'd0);
    for (int i = 0; i < 262; i++) begin
      pending_words.push_back(make_word(OP_RESET, $urandom, 4'($urandom_range(0, 15))));
      pending_words.push_back(make_word(OP_ALLOC, $urandom_range(4097, 8192),
                                        4'($urandom_range(0, 12))));
      if ($urandom_range(0, 3) == 0) pending_words.push_back(random_word());
    end
    drain();

    // Largest first block, with neither side idling.
    write_reg(CFG_FIRST_BLOCK, 32'hFFFF_FFFF);
    steady_send = 1'b1;
    steady_take = 1'b1;
    run_random(150);
    steady_send = 1'b0;
    steady_take = 1'b0;

    // A limit below the first block makes every word a configuration error.
    write_reg(CFG_BYTE_LIMIT, 32'd1);
    run_random(25);

    write_reg(CFG_BYTE_LIMIT, 32'd30000);
    write_reg(CFG_FIRST_BLOCK, 32'd100);
    run_random(200);

    // The receiver holds off while words keep coming, so the input backs up.
    write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_FIRST_BLOCK, 32'd5000);
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    steady_send = 1'b1;
    for (int i = 0; i < 40; i++) pending_words.push_back(random_word());
    while (pending_words.size() != 0) @(posedge clk);
    steady_send = 1'b0;
    run_random(210);

    write_reg(CFG_FIRST_BLOCK, 32'd4096);
    write_reg(CFG_BYTE_LIMIT, 32'd4096);
    run_random(100);

    write_reg(CFG_BYTE_LIMIT, 32'd0);
    write_reg(CFG_FIRST_BLOCK, 32'h0001_0000);
    run_random(100);

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
